// ----- rtl/sit_pkg.sv -----
// shared types, widths and index codes for the segment intersection test
`default_nettype none

package sit_pkg;

	// port width of every coordinate field
	localparam int PORT_BITS = 32;
	// low bits of each coordinate that take part, sign-extended (4 to 32)
	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		pt_t a;
		pt_t b;
		pt_t c;
		pt_t d;
	} pts_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
	} vec_t;

	// difference vectors, named end minus start
	localparam int DIFF_BA  = 0;
	localparam int DIFF_CA  = 1;
	localparam int DIFF_DA  = 2;
	localparam int DIFF_DC  = 3;
	localparam int DIFF_AC  = 4;
	localparam int DIFF_BC  = 5;
	localparam int DIFF_BD  = 6;
	localparam int DIFF_DB  = 7;
	localparam int NUM_DIFF = 8;

	typedef vec_t [NUM_DIFF-1:0] diffs_t;

	typedef struct packed {
		prod_t p;
		prod_t q;
	} pair_t;

	// one test per endpoint against the other segment:
	// C and D against AB, A and B against CD
	localparam int TEST_C_AB = 0;
	localparam int TEST_D_AB = 1;
	localparam int TEST_A_CD = 2;
	localparam int TEST_B_CD = 3;
	localparam int NUM_TEST  = 4;

	// product pairs: cross pairs first, dot pairs after them
	localparam int NUM_PAIR = 2 * NUM_TEST;

	typedef pair_t [NUM_PAIR-1:0] pairs_t;

	typedef struct packed {
		logic [NUM_TEST-1:0] neg;
		logic [NUM_TEST-1:0] zero;
		logic [NUM_TEST-1:0] dot_ok;
	} sign_t;

endpackage

`default_nettype wire

// ----- rtl/sit_diff_stage.sv -----
// stage one: coordinate differences for all cross and dot products
`default_nettype none

module sit_diff_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pts_valid,
	output logic                 pts_stall,
	input  wire sit_pkg::pts_t   pts,
	output logic                 dif_valid,
	input  wire logic            dif_stall,
	output sit_pkg::diffs_t      diffs
);

	logic            valid_s1;
	sit_pkg::diffs_t diffs_s1;
	sit_pkg::diffs_t diffs_next;
	logic            load;

	function automatic sit_pkg::vec_t vsub(sit_pkg::pt_t e, sit_pkg::pt_t s);
		sit_pkg::vec_t r;
		r.x = sit_pkg::diff_t'($signed(e.x)) - sit_pkg::diff_t'($signed(s.x));
		r.y = sit_pkg::diff_t'($signed(e.y)) - sit_pkg::diff_t'($signed(s.y));
		return r;
	endfunction

	always_comb begin
		diffs_next                   = '0;
		diffs_next[sit_pkg::DIFF_BA] = vsub(pts.b, pts.a);
		diffs_next[sit_pkg::DIFF_CA] = vsub(pts.c, pts.a);
		diffs_next[sit_pkg::DIFF_DA] = vsub(pts.d, pts.a);
		diffs_next[sit_pkg::DIFF_DC] = vsub(pts.d, pts.c);
		diffs_next[sit_pkg::DIFF_AC] = vsub(pts.a, pts.c);
		diffs_next[sit_pkg::DIFF_BC] = vsub(pts.b, pts.c);
		diffs_next[sit_pkg::DIFF_BD] = vsub(pts.b, pts.d);
		diffs_next[sit_pkg::DIFF_DB] = vsub(pts.d, pts.b);
	end

	assign pts_stall = valid_s1 && dif_stall;
	assign load      = !pts_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= pts_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && pts_valid) begin
			diffs_s1 <= diffs_next;
		end
	end

	assign dif_valid = valid_s1;
	assign diffs     = diffs_s1;

endmodule

`default_nettype wire

// ----- rtl/sit_mul_stage.sv -----
// stage two: the sixteen signed products of the cross and dot terms
`default_nettype none

module sit_mul_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            dif_valid,
	output logic                 dif_stall,
	input  wire sit_pkg::diffs_t diffs,
	output logic                 prd_valid,
	input  wire logic            prd_stall,
	output sit_pkg::pairs_t      pairs
);

	logic            valid_s2;
	sit_pkg::pairs_t pairs_s2;
	sit_pkg::pairs_t pairs_next;
	logic            load;

	// cross(w, u) = w.x*u.y - w.y*u.x, kept as the two products
	function automatic sit_pkg::pair_t cross_pair(sit_pkg::vec_t w, sit_pkg::vec_t u);
		sit_pkg::pair_t r;
		r.p = $signed(w.x) * $signed(u.y);
		r.q = $signed(w.y) * $signed(u.x);
		return r;
	endfunction

	// dot(u, v) = u.x*v.x + u.y*v.y, kept as the two products
	function automatic sit_pkg::pair_t dot_pair(sit_pkg::vec_t u, sit_pkg::vec_t v);
		sit_pkg::pair_t r;
		r.p = $signed(u.x) * $signed(v.x);
		r.q = $signed(u.y) * $signed(v.y);
		return r;
	endfunction

	always_comb begin
		pairs_next = '0;
		pairs_next[sit_pkg::TEST_C_AB] =
			cross_pair(diffs[sit_pkg::DIFF_BA], diffs[sit_pkg::DIFF_CA]);
		pairs_next[sit_pkg::TEST_D_AB] =
			cross_pair(diffs[sit_pkg::DIFF_BA], diffs[sit_pkg::DIFF_DA]);
		pairs_next[sit_pkg::TEST_A_CD] =
			cross_pair(diffs[sit_pkg::DIFF_DC], diffs[sit_pkg::DIFF_AC]);
		pairs_next[sit_pkg::TEST_B_CD] =
			cross_pair(diffs[sit_pkg::DIFF_DC], diffs[sit_pkg::DIFF_BC]);
		pairs_next[sit_pkg::NUM_TEST + sit_pkg::TEST_C_AB] =
			dot_pair(diffs[sit_pkg::DIFF_CA], diffs[sit_pkg::DIFF_BC]);
		pairs_next[sit_pkg::NUM_TEST + sit_pkg::TEST_D_AB] =
			dot_pair(diffs[sit_pkg::DIFF_DA], diffs[sit_pkg::DIFF_BD]);
		pairs_next[sit_pkg::NUM_TEST + sit_pkg::TEST_A_CD] =
			dot_pair(diffs[sit_pkg::DIFF_AC], diffs[sit_pkg::DIFF_DA]);
		pairs_next[sit_pkg::NUM_TEST + sit_pkg::TEST_B_CD] =
			dot_pair(diffs[sit_pkg::DIFF_BC], diffs[sit_pkg::DIFF_DB]);
	end

	assign dif_stall = valid_s2 && prd_stall;
	assign load      = !dif_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= dif_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && dif_valid) begin
			pairs_s2 <= pairs_next;
		end
	end

	assign prd_valid = valid_s2;
	assign pairs     = pairs_s2;

endmodule

`default_nettype wire

// ----- rtl/sit_sign_stage.sv -----
// stage three: exact signs of the cross products and dot products
`default_nettype none

module sit_sign_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            prd_valid,
	output logic                 prd_stall,
	input  wire sit_pkg::pairs_t pairs,
	output logic                 sgn_valid,
	input  wire logic            sgn_stall,
	output sit_pkg::sign_t       signs
);

	logic           valid_s3;
	sit_pkg::sign_t signs_s3;
	sit_pkg::sign_t signs_next;
	logic           load;

	always_comb begin
		sit_pkg::sum_t d;
		sit_pkg::sum_t s;
		signs_next = '0;
		for (int k = 0; k < sit_pkg::NUM_TEST; k++) begin
			d = sit_pkg::sum_t'($signed(pairs[k].p)) -
				sit_pkg::sum_t'($signed(pairs[k].q));
			s = sit_pkg::sum_t'($signed(pairs[sit_pkg::NUM_TEST + k].p)) +
				sit_pkg::sum_t'($signed(pairs[sit_pkg::NUM_TEST + k].q));
			signs_next.neg[k]    = d[sit_pkg::SUM_BITS-1];
			signs_next.zero[k]   = (d == '0);
			signs_next.dot_ok[k] = !s[sit_pkg::SUM_BITS-1];
		end
	end

	assign prd_stall = valid_s3 && sgn_stall;
	assign load      = !prd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= prd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && prd_valid) begin
			signs_s3 <= signs_next;
		end
	end

	assign sgn_valid = valid_s3;
	assign signs     = signs_s3;

endmodule

`default_nettype wire

// ----- rtl/segment_intersection_test.sv -----
// top level of the closed segment intersection test
`default_nettype none

// Tests whether closed segments AB and CD share at least one point. Each coordinate
// port is 32 bits; the low sit_pkg::COORD_BITS bits are taken as a signed value and
// any higher bits are ignored. All signs are exact: differences are one bit wider
// than a coordinate and products twice that, so no input pattern can overflow.
// A proper crossing is reported when each segment's endpoints lie strictly on
// opposite sides of the other; otherwise the result is 1 when some endpoint lies on
// the other segment (zero cross product, non-negative dot product). Point segments
// follow the same rule. Throughput is one word per cycle while res_stall is low. Each
// word passes the four registers in order: differences, sixteen 33x33 products, exact
// sign reduction, then the decision into the output register that drives res_valid.
// The product stage sets the clock. Each stage holds its word while the next one is
// full and stalled, so seg_stall rises only when all four registers are occupied
// and res_stall is high; bubbles are squeezed out.
module segment_intersection_test (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          seg_valid,
	output logic                               seg_stall,
	input  wire logic [sit_pkg::PORT_BITS-1:0] a_x,
	input  wire logic [sit_pkg::PORT_BITS-1:0] a_y,
	input  wire logic [sit_pkg::PORT_BITS-1:0] b_x,
	input  wire logic [sit_pkg::PORT_BITS-1:0] b_y,
	input  wire logic [sit_pkg::PORT_BITS-1:0] c_x,
	input  wire logic [sit_pkg::PORT_BITS-1:0] c_y,
	input  wire logic [sit_pkg::PORT_BITS-1:0] d_x,
	input  wire logic [sit_pkg::PORT_BITS-1:0] d_y,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic                               intersects
);

	sit_pkg::pts_t   pts;
	sit_pkg::diffs_t diffs;
	sit_pkg::pairs_t pairs;
	sit_pkg::sign_t  signs;
	logic            dif_valid;
	logic            dif_stall;
	logic            prd_valid;
	logic            prd_stall;
	logic            sgn_valid;
	logic            sgn_stall;

	// decision stage
	logic [sit_pkg::NUM_TEST-1:0] pos;
	logic                         opp_ab;
	logic                         opp_cd;
	logic                         hit;
	logic                         valid_s4;
	logic                         hit_s4;
	logic                         load;

	// keep the low coordinate bits; the stages sign-extend them
	assign pts.a.x = a_x[sit_pkg::COORD_BITS-1:0];
	assign pts.a.y = a_y[sit_pkg::COORD_BITS-1:0];
	assign pts.b.x = b_x[sit_pkg::COORD_BITS-1:0];
	assign pts.b.y = b_y[sit_pkg::COORD_BITS-1:0];
	assign pts.c.x = c_x[sit_pkg::COORD_BITS-1:0];
	assign pts.c.y = c_y[sit_pkg::COORD_BITS-1:0];
	assign pts.d.x = d_x[sit_pkg::COORD_BITS-1:0];
	assign pts.d.y = d_y[sit_pkg::COORD_BITS-1:0];

	sit_diff_stage u_diff (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts_valid (seg_valid),
		.pts_stall (seg_stall),
		.pts       (pts),
		.dif_valid (dif_valid),
		.dif_stall (dif_stall),
		.diffs     (diffs)
	);

	sit_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.dif_valid (dif_valid),
		.dif_stall (dif_stall),
		.diffs     (diffs),
		.prd_valid (prd_valid),
		.prd_stall (prd_stall),
		.pairs     (pairs)
	);

	sit_sign_stage u_sign (
		.clk       (clk),
		.arst_n    (arst_n),
		.prd_valid (prd_valid),
		.prd_stall (prd_stall),
		.pairs     (pairs),
		.sgn_valid (sgn_valid),
		.sgn_stall (sgn_stall),
		.signs     (signs)
	);

	// strictly positive orientation
	assign pos = ~signs.neg & ~signs.zero;

	// C and D strictly on opposite sides of AB, likewise A and B of CD
	assign opp_ab = (signs.neg[sit_pkg::TEST_C_AB] && pos[sit_pkg::TEST_D_AB]) ||
		(pos[sit_pkg::TEST_C_AB] && signs.neg[sit_pkg::TEST_D_AB]);
	assign opp_cd = (signs.neg[sit_pkg::TEST_A_CD] && pos[sit_pkg::TEST_B_CD]) ||
		(pos[sit_pkg::TEST_A_CD] && signs.neg[sit_pkg::TEST_B_CD]);

	// an endpoint on the other segment: its orientation cross product is zero
	// (the same zero as the on-segment cross term) and it lies between the ends
	assign hit = (opp_ab && opp_cd) || (|(signs.zero & signs.dot_ok));

	// output register parts the pipeline from the result side
	assign sgn_stall = valid_s4 && res_stall;
	assign load      = !sgn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (load) begin
			valid_s4 <= sgn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && sgn_valid) begin
			hit_s4 <= hit;
		end
	end

	assign res_valid  = valid_s4;
	assign intersects = hit_s4;

endmodule

`default_nettype wire

// ----- rtl/sit_checker.sv -----
// port-level checks for the segment intersection test and their binding
`default_nettype none

module sit_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          seg_valid,
	input wire logic                          seg_stall,
	input wire logic [sit_pkg::PORT_BITS-1:0] a_x,
	input wire logic [sit_pkg::PORT_BITS-1:0] a_y,
	input wire logic [sit_pkg::PORT_BITS-1:0] c_x,
	input wire logic [sit_pkg::PORT_BITS-1:0] c_y,
	input wire logic                          res_valid,
	input wire logic                          res_stall,
	input wire logic                          intersects
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(intersects))
		else $error("stalled result changed");

	// input backs up only when the whole pipeline is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> res_valid && res_stall)
		else $error("input stalled while pipeline has room");

	// with res_stall low behind it, an accepted word comes out on res_valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall
		|=> res_valid)
		else $error("result missing after pipeline latency");

	// segments that share a start point always intersect
	assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg_stall && a_x == c_x && a_y == c_y)
		##1 !res_stall ##1 !res_stall ##1 !res_stall |=> intersects)
		else $error("shared endpoint not reported");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.seg_valid  (seg_valid),
	.seg_stall  (seg_stall),
	.a_x        (a_x),
	.a_y        (a_y),
	.c_x        (c_x),
	.c_y        (c_y),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.intersects (intersects)
);

`default_nettype wire
